>>> hw/rtl/cms_pkg.sv
`default_nettype none
package cms_pkg;

	typedef struct packed {
		logic [10:0] w;
		logic [3:0]  d;
		logic [1:0]  csz;
	} cfg_t;

	localparam logic [31:0] MM_MUL = 32'h5bd1e995;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVER  = 2'd1;
	localparam logic [1:0] ST_UNDER = 2'd2;

	localparam logic [1:0] REG_ROW_WIDTH = 2'd0;
	localparam logic [1:0] REG_ROW_COUNT = 2'd1;
	localparam logic [1:0] REG_CELL_SIZE = 2'd2;

	localparam logic CMD_INC   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam int KEY_BYTES = 8;
	localparam logic [3:0] KLEN_MAX = (KEY_BYTES > 8) ? 4'd8 : 4'(KEY_BYTES);

	function automatic logic [63:0] cell_max(input logic [1:0] csz);
		logic [63:0] m;
		case (csz)
			2'd0: m = 64'h0000_0000_0000_00ff;
			2'd1: m = 64'h0000_0000_0000_ffff;
			2'd2: m = 64'h0000_0000_ffff_ffff;
			default: m = 64'h7fff_ffff_ffff_ffff;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] cell_mask(input logic [1:0] csz);
		logic [63:0] m;
		case (csz)
			2'd0: m = 64'h0000_0000_0000_00ff;
			2'd1: m = 64'h0000_0000_0000_ffff;
			2'd2: m = 64'h0000_0000_ffff_ffff;
			default: m = 64'hffff_ffff_ffff_ffff;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cms_ram.sv
`default_nettype none
module cms_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/cms_queue.sv
`default_nettype none
module cms_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic              empty,
	output logic      [W-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [W-1:0]   ent_q [DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [CNW-1:0] cnt_q;
	logic           do_push, do_pop;

	assign full    = cnt_q == CNW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= wdata;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/cms_front.sv
`default_nettype none
module cms_front #(
	parameter int MAX_ROWS = 8,
	parameter int CW       = 10,
	parameter int RW       = 3
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cms_pkg::cfg_t            cfg,
	input  wire logic                     take,
	input  wire logic                     command,
	input  wire logic [63:0]              key,
	input  wire logic [3:0]               key_len,
	input  wire logic [63:0]              delta,
	output logic                          busy,
	output logic                          q_push,
	input  wire logic                     q_full,
	output logic                          q_cmd,
	output logic      [63:0]              q_delta,
	output logic      [MAX_ROWS*CW-1:0]   q_locs
);
	typedef enum logic [9:0] {
		F_IDLE = 10'b00_0000_0001,
		F_KA   = 10'b00_0000_0010,
		F_KB   = 10'b00_0000_0100,
		F_HI   = 10'b00_0000_1000,
		F_HB   = 10'b00_0001_0000,
		F_TL   = 10'b00_0010_0000,
		F_FN   = 10'b00_0100_0000,
		F_DS   = 10'b00_1000_0000,
		F_DV   = 10'b01_0000_0000,
		F_PUSH = 10'b10_0000_0000
	} fstate_t;

	fstate_t                    state_q;
	logic [63:0]                key_q, delta_q;
	logic [3:0]                 klen_q;
	logic                       cmd_q;
	logic                       blk_q;
	logic [31:0]                kb_q [2];
	logic [31:0]                t_q, h_q, dvd_q;
	logic [1:0]                 b_q;
	logic [RW-1:0]              r_q;
	logic [10:0]                rem_q;
	logic [2:0]                 dcnt_q;
	logic [MAX_ROWS-1:0][CW-1:0] loc_q;

	logic [1:0]  nblk;
	logic [3:0]  klen_c;
	logic [31:0] tail_w, tail_m, mop, prod;
	logic [RW-1:0] dm1;
	logic [11:0] dt;
	logic [10:0] rr;

	assign nblk   = klen_q[3:2];
	assign klen_c = (key_len > cms_pkg::KLEN_MAX) ? cms_pkg::KLEN_MAX : key_len;
	assign dm1    = RW'(cfg.d - 4'd1);
	assign tail_w = nblk[0] ? key_q[63:32] : key_q[31:0];

	always_comb begin
		case (klen_q[1:0])
			2'd1: tail_m = 32'h0000_00ff;
			2'd2: tail_m = 32'h0000_ffff;
			2'd3: tail_m = 32'h00ff_ffff;
			default: tail_m = 32'h0;
		endcase
	end

	always_comb begin
		case (state_q)
			F_KA: mop = blk_q ? key_q[63:32] : key_q[31:0];
			F_KB: mop = t_q ^ (t_q >> 24);
			F_TL: mop = h_q ^ (tail_w & tail_m);
			F_FN: mop = h_q ^ (h_q >> 13);
			default: mop = h_q;
		endcase
		prod = mop * cms_pkg::MM_MUL;
	end

	always_comb begin
		rr = rem_q;
		for (int i = 0; i < 4; i++) begin
			dt = {rr, dvd_q[31-i]};
			rr = (dt >= {1'b0, cfg.w}) ? 11'(dt - {1'b0, cfg.w}) : dt[10:0];
		end
	end

	assign busy    = state_q != F_IDLE;
	assign q_push  = (state_q == F_PUSH) && !q_full;
	assign q_cmd   = cmd_q;
	assign q_delta = delta_q;
	assign q_locs  = loc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			blk_q   <= 1'b0;
			b_q     <= '0;
			r_q     <= '0;
			dcnt_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (take) begin
						blk_q   <= 1'b0;
						r_q     <= '0;
						state_q <= (klen_c[3:2] != 2'd0) ? F_KA : F_HI;
					end
				end
				F_KA: state_q <= F_KB;
				F_KB: begin
					if ({1'b0, blk_q} == nblk - 2'd1) begin
						state_q <= F_HI;
					end else begin
						blk_q   <= 1'b1;
						state_q <= F_KA;
					end
				end
				F_HI: begin
					b_q     <= '0;
					state_q <= F_HB;
				end
				F_HB: begin
					if (b_q == nblk) begin
						state_q <= F_TL;
					end else begin
						b_q <= b_q + 2'd1;
					end
				end
				F_TL: state_q <= F_FN;
				F_FN: state_q <= F_DS;
				F_DS: begin
					dcnt_q  <= '0;
					state_q <= F_DV;
				end
				F_DV: begin
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'd7) begin
						if (r_q == dm1) begin
							state_q <= F_PUSH;
						end else begin
							r_q     <= r_q + 1'b1;
							state_q <= F_HI;
						end
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (take) begin
					key_q   <= key;
					klen_q  <= klen_c;
					cmd_q   <= command;
					delta_q <= delta;
				end
			end
			F_KA: t_q <= prod;
			F_KB: kb_q[blk_q] <= prod;
			F_HI: h_q <= 32'(r_q) ^ {28'd0, klen_q};
			F_HB: begin
				if (b_q != nblk) begin
					h_q <= prod ^ kb_q[b_q[0]];
				end
			end
			F_TL: begin
				if (klen_q[1:0] != 2'd0) begin
					h_q <= prod;
				end
			end
			F_FN: h_q <= prod;
			F_DS: begin
				dvd_q <= h_q ^ (h_q >> 15);
				rem_q <= '0;
			end
			F_DV: begin
				rem_q <= rr;
				dvd_q <= dvd_q << 4;
				if (dcnt_q == 3'd7) begin
					loc_q[r_q] <= CW'(rr);
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> hw/rtl/cms_back.sv
`default_nettype none
module cms_back #(
	parameter int MAX_ROWS = 8,
	parameter int CW       = 10,
	parameter int RW       = 3,
	parameter int AW       = 13
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cms_pkg::cfg_t          cfg,
	input  wire logic                   q_empty,
	output logic                        q_pop,
	input  wire logic                   q_cmd,
	input  wire logic [63:0]            q_delta,
	input  wire logic [MAX_ROWS*CW-1:0] q_locs,
	output logic      [AW-1:0]          ram_raddr,
	input  wire logic [63:0]            ram_rdata,
	output logic                        ram_we,
	output logic      [AW-1:0]          ram_waddr,
	output logic      [63:0]            ram_wdata,
	output logic                        clearing,
	input  wire logic                   pop,
	output logic                        empty,
	output logic      [63:0]            estimate,
	output logic      [1:0]             status
);
	typedef enum logic [7:0] {
		B_CLR  = 8'b0000_0001,
		B_IDLE = 8'b0000_0010,
		B_RA   = 8'b0000_0100,
		B_CK   = 8'b0000_1000,
		B_TOT  = 8'b0001_0000,
		B_WA   = 8'b0010_0000,
		B_WR   = 8'b0100_0000,
		B_OUT  = 8'b1000_0000
	} bstate_t;

	bstate_t                     state_q;
	logic [AW-1:0]               clr_q;
	logic                        cmd_q, neg_q, pos_q;
	logic [63:0]                 mag_q, minv_q;
	logic [MAX_ROWS-1:0][CW-1:0] locs_q;
	logic [RW-1:0]               r_q;
	logic [1:0]                  st_q;
	logic [62:0]                 total_q;
	logic                        out_valid_q;
	logic [63:0]                 estimate_q;
	logic [1:0]                  status_q;

	logic [63:0] c, cmax, u, minc, minu;
	logic        over, under, last, load;
	logic [RW-1:0] dm1;

	assign dm1   = RW'(cfg.d - 4'd1);
	assign last  = r_q == dm1;
	assign c     = ram_rdata & cms_pkg::cell_mask(cfg.csz);
	assign cmax  = cms_pkg::cell_max(cfg.csz);
	assign over  = pos_q && ((c > cmax) || (mag_q > cmax - c));
	assign under = neg_q && (mag_q > c);
	assign u     = neg_q ? c - mag_q : c + mag_q;
	assign minc  = (c < minv_q) ? c : minv_q;
	assign minu  = (u < minv_q) ? u : minv_q;

	assign ram_raddr = {r_q, locs_q[r_q]};
	assign ram_we    = (state_q == B_CLR) || (state_q == B_WR);
	assign ram_waddr = (state_q == B_CLR) ? clr_q : ram_raddr;
	assign ram_wdata = (state_q == B_CLR) ? 64'd0 : u;

	assign clearing = state_q == B_CLR;
	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign load     = (state_q == B_OUT) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;
	assign estimate = estimate_q;
	assign status   = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLR;
			clr_q       <= '0;
			r_q         <= '0;
			st_q        <= cms_pkg::ST_OK;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (!q_empty) begin
						r_q     <= '0;
						st_q    <= cms_pkg::ST_OK;
						state_q <= B_RA;
					end
				end
				B_RA: state_q <= B_CK;
				B_CK: begin
					if (cmd_q == cms_pkg::CMD_INC) begin
						if (over) begin
							st_q <= cms_pkg::ST_OVER;
						end else if (under) begin
							st_q <= cms_pkg::ST_UNDER;
						end
					end
					if (last) begin
						state_q <= (cmd_q == cms_pkg::CMD_QUERY) ? B_OUT : B_TOT;
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= B_RA;
					end
				end
				B_TOT: begin
					if (st_q != cms_pkg::ST_OK) begin
						state_q <= B_OUT;
					end else if (pos_q && (mag_q > {1'b0, ~total_q})) begin
						st_q    <= cms_pkg::ST_OVER;
						state_q <= B_OUT;
					end else if (neg_q && (mag_q > {1'b0, total_q})) begin
						st_q    <= cms_pkg::ST_UNDER;
						state_q <= B_OUT;
					end else begin
						r_q     <= '0;
						state_q <= B_WA;
					end
				end
				B_WA: state_q <= B_WR;
				B_WR: begin
					if (last) begin
						total_q <= neg_q ? total_q - mag_q[62:0] : total_q + mag_q[62:0];
						state_q <= B_OUT;
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= B_WA;
					end
				end
				B_OUT: begin
					if (load) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					cmd_q  <= q_cmd;
					neg_q  <= q_delta[63];
					pos_q  <= !q_delta[63] && (q_delta != 64'd0);
					mag_q  <= q_delta[63] ? 64'd0 - q_delta : q_delta;
					locs_q <= q_locs;
					minv_q <= '1;
				end
			end
			B_CK: begin
				if (cmd_q == cms_pkg::CMD_QUERY) begin
					minv_q <= minc;
				end
			end
			B_TOT: minv_q <= '1;
			B_WR: minv_q <= minu;
			default: ;
		endcase
		if (load) begin
			estimate_q <= (st_q == cms_pkg::ST_OK) ? minv_q : 64'd0;
			status_q   <= st_q;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/count_min_sketch_update_query.sv
`default_nettype none
// Count-min sketch with increment and query, one result per item, in order.
// The front hashes the key once per active row with a single shared 32-bit
// multiplier and reduces each hash modulo the row width four bits a cycle;
// key_len is clamped to eight, and the front sets the sustained rate. The back
// reads the selected counters in one pass and, for an accepted increment,
// writes them in a second pass through the write port of the counter memory;
// a two-entry queue lets the front and the back run at once. After reset the
// counter memory is cleared one cell a cycle over all 2**ceil(log2(MAX_ROWS))
// * 2**ceil(log2(MAX_ROW_WIDTH)) cells (8192 by default), and full stays high
// until it is done. Configuration is taken at any time but must only change
// while no item is in flight.
module count_min_sketch_update_query #(
	parameter int MAX_ROW_WIDTH = 1024,
	parameter int MAX_ROWS      = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        command,
	input  wire logic [63:0] key,
	input  wire logic [3:0]  key_len,
	input  wire logic signed [63:0] delta,
	input  wire logic        pop,
	output logic             empty,
	output logic      [63:0] estimate,
	output logic      [1:0]  status,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);
	localparam int CW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW = RW + CW;
	localparam int QW = 1 + 64 + MAX_ROWS * CW;
	localparam logic [10:0] WMAX = (MAX_ROW_WIDTH > 2047) ? 11'd2047 : 11'(MAX_ROW_WIDTH);
	localparam logic [3:0]  DMAX = (MAX_ROWS > 15) ? 4'd15 : 4'(MAX_ROWS);

	logic [10:0]   row_width_q;
	logic [3:0]    row_count_q;
	logic [1:0]    cell_size_code_q;
	cms_pkg::cfg_t cfg_c;

	logic front_busy, clearing, take;
	logic q_push, q_full, q_pop, q_empty;
	logic f_cmd, b_cmd;
	logic [63:0] f_delta, b_delta;
	logic [MAX_ROWS*CW-1:0] f_locs, b_locs;
	logic [AW-1:0] ram_raddr, ram_waddr;
	logic [63:0]   ram_rdata, ram_wdata;
	logic          ram_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q      <= 11'd1024;
			row_count_q      <= 4'd8;
			cell_size_code_q <= 2'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				cms_pkg::REG_ROW_WIDTH: row_width_q <= cfg_data;
				cms_pkg::REG_ROW_COUNT: row_count_q <= cfg_data[3:0];
				cms_pkg::REG_CELL_SIZE: cell_size_code_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_c.w = (row_width_q == 11'd0) ? 11'd1 :
			((row_width_q > WMAX) ? WMAX : row_width_q);
		cfg_c.d = (row_count_q == 4'd0) ? 4'd1 :
			((row_count_q > DMAX) ? DMAX : row_count_q);
		cfg_c.csz = cell_size_code_q;
	end

	assign full = front_busy || clearing;
	assign take = push && !full;

	cms_front #(.MAX_ROWS(MAX_ROWS), .CW(CW), .RW(RW)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_c), .take(take),
		.command(command), .key(key), .key_len(key_len), .delta(delta),
		.busy(front_busy), .q_push(q_push), .q_full(q_full),
		.q_cmd(f_cmd), .q_delta(f_delta), .q_locs(f_locs)
	);

	cms_queue #(.W(QW), .DEPTH(2)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .full(q_full), .wdata({f_cmd, f_delta, f_locs}),
		.pop(q_pop), .empty(q_empty), .rdata({b_cmd, b_delta, b_locs})
	);

	cms_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	cms_back #(.MAX_ROWS(MAX_ROWS), .CW(CW), .RW(RW), .AW(AW)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_c),
		.q_empty(q_empty), .q_pop(q_pop), .q_cmd(b_cmd), .q_delta(b_delta),
		.q_locs(b_locs),
		.ram_raddr(ram_raddr), .ram_rdata(ram_rdata), .ram_we(ram_we),
		.ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
		.clearing(clearing), .pop(pop), .empty(empty),
		.estimate(estimate), .status(status)
	);

`ifndef SYNTH
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full && empty)
		else $error("item taken or result shown during clearing");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != cms_pkg::ST_OK |-> estimate == 64'd0)
		else $error("rejected item carries an estimate");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("front not busy after taking an item");
`endif
endmodule
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;

	localparam int LIMIT = 3_000_000;
	localparam int ROW_SPAN = 1024;
	localparam logic [63:0] I64_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;

	typedef struct {
		logic        cmd;
		logic [63:0] key;
		logic [3:0]  klen;
		logic [63:0] delta;
	} item_t;

	typedef struct {
		logic [63:0] est;
		logic [1:0]  st;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic command = 1'b0;
	logic [63:0] key = '0;
	logic [3:0] key_len = '0;
	logic signed [63:0] delta = '0;
	logic pop = 1'b0;
	logic empty;
	logic [63:0] estimate;
	logic [1:0] status;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = cms_pkg::REG_ROW_WIDTH;
	logic [10:0] cfg_data = '0;

	count_min_sketch_update_query dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.key(key), .key_len(key_len), .delta(delta), .pop(pop), .empty(empty),
		.estimate(estimate), .status(status), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	item_t pending_items[$];
	answer_t expected_answers[$];
	item_t in_flight;
	logic [63:0] sketch_cells [0:8191];
	logic [63:0] sketch_total;
	logic [10:0] width_reg = 11'd1024;
	logic [3:0] rows_reg = 4'd8;
	logic [1:0] size_reg = 2'd2;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_request = 0;
	bit hold_used = 0;
	int hold_left = 0;
	int errors = 0;
	int cycles = 0;
	logic [63:0] key_pool [0:15];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [31:0] murmur_hash(input logic [63:0] k, input int n,
			input logic [31:0] seed);
		logic [31:0] h;
		logic [31:0] blk;
		int p;
		h = seed ^ 32'(n);
		p = 0;
		while (n - p >= 4) begin
			blk = k[p*8 +: 32];
			blk = blk * cms_pkg::MM_MUL;
			blk = blk ^ (blk >> 24);
			blk = blk * cms_pkg::MM_MUL;
			h = h * cms_pkg::MM_MUL;
			h = h ^ blk;
			p += 4;
		end
		if (n - p >= 3) h = h ^ (32'(k[(p+2)*8 +: 8]) << 16);
		if (n - p >= 2) h = h ^ (32'(k[(p+1)*8 +: 8]) << 8);
		if (n - p >= 1) begin
			h = h ^ 32'(k[p*8 +: 8]);
			h = h * cms_pkg::MM_MUL;
		end
		h = h ^ (h >> 13);
		h = h * cms_pkg::MM_MUL;
		h = h ^ (h >> 15);
		return h;
	endfunction

	function automatic answer_t sketch_update(input item_t it);
		answer_t a;
		int w, d, n;
		int loc [0:7];
		logic [63:0] cmax, cmask, mag, c, u, minv;
		logic neg, posv;
		w = (width_reg == 0) ? 1 : (width_reg > ROW_SPAN ? ROW_SPAN : int'(width_reg));
		d = (rows_reg == 0) ? 1 : (rows_reg > 8 ? 8 : int'(rows_reg));
		n = (it.klen > 8) ? 8 : int'(it.klen);
		case (size_reg)
			2'd0: cmax = 64'hff;
			2'd1: cmax = 64'hffff;
			2'd2: cmax = 64'hffff_ffff;
			default: cmax = I64_MAX;
		endcase
		cmask = (size_reg == 2'd3) ? '1 : cmax;
		neg = it.delta[63];
		mag = neg ? -it.delta : it.delta;
		posv = !neg && it.delta != 0;
		minv = '1;
		a.st = cms_pkg::ST_OK;
		for (int r = 0; r < d; r++)
			loc[r] = int'(murmur_hash(it.key, n, 32'(r)) % 32'(w)) + r * ROW_SPAN;
		if (it.cmd == cms_pkg::CMD_QUERY) begin
			for (int r = 0; r < d; r++) begin
				c = sketch_cells[loc[r]] & cmask;
				if (c < minv) minv = c;
			end
			a.est = minv;
			return a;
		end
		for (int r = 0; r < d && a.st == cms_pkg::ST_OK; r++) begin
			c = sketch_cells[loc[r]] & cmask;
			if (posv && (c > cmax || mag > cmax - c)) a.st = cms_pkg::ST_OVER;
			else if (neg && mag > c) a.st = cms_pkg::ST_UNDER;
		end
		if (a.st == cms_pkg::ST_OK) begin
			if (posv && mag > I64_MAX - sketch_total) a.st = cms_pkg::ST_OVER;
			else if (neg && mag > sketch_total) a.st = cms_pkg::ST_UNDER;
		end
		if (a.st != cms_pkg::ST_OK) begin
			a.est = '0;
			return a;
		end
		for (int r = 0; r < d; r++) begin
			c = sketch_cells[loc[r]] & cmask;
			u = neg ? c - mag : c + mag;
			sketch_cells[loc[r]] = u;
			if (u < minv) minv = u;
		end
		sketch_total = neg ? sketch_total - mag : sketch_total + mag;
		a.est = minv;
		return a;
	endfunction

	always @(posedge clk) begin
		if (push && !full)
			expected_answers.push_back(sketch_update(in_flight));
		if (!push || !full) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_flight = pending_items.pop_front();
				push <= 1'b1;
				command <= in_flight.cmd;
				key <= in_flight.key;
				key_len <= in_flight.klen;
				delta <= in_flight.delta;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_request && !hold_used && push && arst_n) begin
			hold_left <= 4000;
			hold_used <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (pop && !empty) begin
			if (expected_answers.size() == 0) begin
				$error("unexpected item: estimate %h status %0d", estimate, status);
				errors++;
			end else begin
				e = expected_answers.pop_front();
				if (estimate !== e.est) begin
					$error("estimate: expected %h, got %h", e.est, estimate);
					errors++;
				end
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status);
					errors++;
				end
			end
		end
		if (hold_left > 0) begin
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic set_config(input logic [10:0] w, input logic [3:0] d, input logic [1:0] s);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= cms_pkg::REG_ROW_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= cms_pkg::REG_ROW_COUNT;
		cfg_data <= 11'(d);
		@(posedge clk);
		cfg_index <= cms_pkg::REG_CELL_SIZE;
		cfg_data <= 11'(s);
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg = w;
		rows_reg = d;
		size_reg = s;
	endtask

	task automatic add_item(input logic c, input logic [63:0] k, input logic [3:0] n,
			input logic [63:0] dv);
		item_t it;
		it.cmd = c;
		it.key = k;
		it.klen = n;
		it.delta = dv;
		pending_items.push_back(it);
	endtask

	task automatic add_random(input int count);
		logic [63:0] dv;
		logic [63:0] k;
		int sel;
		for (int i = 0; i < count; i++) begin
			k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(15)]
				: {$urandom, $urandom};
			sel = $urandom_range(99);
			if (sel < 50) dv = 64'($urandom_range(40, 1));
			else if (sel < 75) dv = -64'($urandom_range(40, 1));
			else if (sel < 80) dv = '0;
			else if (sel < 92) dv = {$urandom, $urandom};
			else if (sel < 96) dv = I64_MAX;
			else dv = I64_MIN;
			add_item($urandom_range(99) < 30, k, 4'($urandom_range(15)), dv);
		end
	endtask

	task automatic drain;
		while (pending_items.size() > 0 || push || expected_answers.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < 8192; i++) sketch_cells[i] = '0;
		sketch_total = '0;
		for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		set_config(11'd1024, 4'd8, 2'd2);
		add_item(cms_pkg::CMD_QUERY, 64'h0, 4'd0, 64'h0);
		add_item(cms_pkg::CMD_INC, 64'h0, 4'd0, 64'h0);
		for (int n = 0; n <= 8; n++)
			add_item(cms_pkg::CMD_INC, 64'hffff_ffff_ffff_ffff, 4'(n), 64'(n + 1));
		add_item(cms_pkg::CMD_INC, 64'h0123_4567_89ab_cdef, 4'd15, 64'd3);
		add_item(cms_pkg::CMD_QUERY, 64'h0123_4567_89ab_cdef, 4'd8, 64'h0);
		add_item(cms_pkg::CMD_INC, 64'h0123_4567_89ab_cdef, 4'd8, -64'd3);
		add_item(cms_pkg::CMD_INC, 64'h0123_4567_89ab_cdef, 4'd8, -64'd1);
		add_item(cms_pkg::CMD_INC, 64'h55, 4'd1, I64_MAX);
		add_item(cms_pkg::CMD_INC, 64'h55, 4'd1, I64_MIN);
		add_item(cms_pkg::CMD_INC, 64'h55, 4'd1, 64'hffff_fffe);
		add_item(cms_pkg::CMD_INC, 64'h55, 4'd1, 64'd1);
		add_item(cms_pkg::CMD_INC, 64'h55, 4'd1, 64'd1);
		add_item(cms_pkg::CMD_QUERY, 64'h55, 4'd1, 64'hffff_ffff_ffff_ffff);
		add_item(cms_pkg::CMD_INC, 64'h55, 4'd1, -64'hffff_ffff);
		drain();

		set_config(11'd1, 4'd1, 2'd0);
		tx_idle_pct = 85;
		add_random(250);
		drain();

		set_config(11'd1024, 4'd8, 2'd3);
		tx_idle_pct = 0;
		rx_stall_pct = 85;
		add_item(cms_pkg::CMD_INC, 64'haa, 4'd1, I64_MAX - sketch_total);
		add_item(cms_pkg::CMD_INC, 64'hbb, 4'd1, 64'd1);
		add_item(cms_pkg::CMD_INC, 64'haa, 4'd1, -(I64_MAX - sketch_total));
		hold_request = 1;
		add_random(250);
		drain();

		set_config(11'd7, 4'd3, 2'd1);
		tx_idle_pct = 7;
		rx_stall_pct = 7;
		add_random(250);
		drain();

		set_config(11'd2047, 4'd15, 2'd0);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		add_random(250);
		drain();

		set_config(11'd0, 4'd0, 2'd2);
		tx_idle_pct = 85;
		rx_stall_pct = 85;
		add_random(250);
		drain();

		set_config(11'd100, 4'd5, 2'd3);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		add_random(250);
		drain();

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
